/* rtl/core/mvm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mvm_pkg
// Shared types and constants of the multi-voice sample mixer.
// ----------------------------------------------------------------------------
package mvm_pkg;

    localparam int VOICE_COUNT_DEF = 16;
    localparam int SOUND_COUNT_DEF = 7;
    localparam int MAX_FRAMES_DEF  = 16384;

    localparam int GAIN_W = 20;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 20'd655360;
    localparam logic [GAIN_W-1:0] GAIN_STEP  = 20'd256;
    localparam logic [3:0] VOL_MAX = 4'd10;
    localparam logic [6:0] FADE_LEN = 7'd96;

    // ceil(2^17 / 3): exact quotient for dividends below 2^17.
    localparam logic [32:0] RECIP3 = 33'd43691;
    // ceil(2^35 / 10): exact quotient for dividends below 2^32.
    localparam logic [31:0] RECIP10 = 32'hCCCCCCCD;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_LENGTH  = 2'd1,
        OP_TRIGGER = 2'd2,
        OP_FRAME   = 2'd3
    } op_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic issue;
        logic mul;
        logic div;
        logic sat;
    } cmd_t;

endpackage

`default_nettype wire

/* rtl/core/mvm_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mvm_ctrl
// Sequencer: walks the voices for an output frame, then the scaling steps.
// ----------------------------------------------------------------------------
module mvm_ctrl #(
    parameter int VOICE_COUNT = mvm_pkg::VOICE_COUNT_DEF,
    localparam int IW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [1:0]    op,
    output logic               busy,
    output logic               done,
    output logic [IW-1:0]      voice_idx,
    output mvm_pkg::cmd_t      cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_VOICE,
        ST_DRAIN,
        ST_MUL,
        ST_DIV,
        ST_SAT
    } state_t;

    localparam logic [IW-1:0] LAST_VOICE = IW'(VOICE_COUNT - 1);

    state_t        state_reg;
    logic [IW-1:0] idx_reg;
    logic [1:0]    drain_reg;
    logic          done_reg;
    logic          accept;

    assign accept = start && (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            drain_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == ST_SAT);
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && (op == mvm_pkg::OP_FRAME))
                    begin
                        state_reg <= ST_VOICE;
                        idx_reg   <= '0;
                    end
                end
                ST_VOICE:
                begin
                    if (idx_reg == LAST_VOICE)
                    begin
                        state_reg <= ST_DRAIN;
                        drain_reg <= '0;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_DRAIN:
                begin
                    // The last voice passes the fade registers into the accumulator.
                    if (drain_reg == 2'd2)
                        state_reg <= ST_MUL;
                    drain_reg <= drain_reg + 1'b1;
                end
                ST_MUL:  state_reg <= ST_DIV;
                ST_DIV:  state_reg <= ST_SAT;
                ST_SAT:  state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign voice_idx  = idx_reg;
    assign cmd.accept = accept;
    assign cmd.issue  = (state_reg == ST_VOICE);
    assign cmd.mul    = (state_reg == ST_MUL);
    assign cmd.div    = (state_reg == ST_DIV);
    assign cmd.sat    = (state_reg == ST_SAT);

endmodule

`default_nettype wire

/* rtl/core/mvm_dpath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mvm_dpath
// Sound memory, voice state, per-voice fade pipeline and master scaling.
// ----------------------------------------------------------------------------
module mvm_dpath #(
    parameter int VOICE_COUNT = mvm_pkg::VOICE_COUNT_DEF,
    parameter int SOUND_COUNT = mvm_pkg::SOUND_COUNT_DEF,
    parameter int MAX_FRAMES  = mvm_pkg::MAX_FRAMES_DEF,
    localparam int IW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire mvm_pkg::cmd_t      cmd,
    input  wire logic [IW-1:0]      voice_idx,
    input  wire logic [1:0]         op,
    input  wire logic [7:0]         sound_index,
    input  wire logic [13:0]        frame_address,
    input  wire logic signed [15:0] left_in,
    input  wire logic signed [15:0] right_in,
    input  wire logic [14:0]        sound_length,
    input  wire logic [3:0]         volume_level,
    output logic signed [15:0]      left_out,
    output logic signed [15:0]      right_out,
    output logic                    any_active
);

    localparam int SW = (SOUND_COUNT > 1) ? $clog2(SOUND_COUNT) : 1;
    localparam int FW = $clog2(MAX_FRAMES + 1);
    localparam int DEPTH = SOUND_COUNT * MAX_FRAMES;
    localparam int AW = $clog2(DEPTH);
    localparam int ACC_W = 17 + $clog2(VOICE_COUNT);
    localparam int PW = ACC_W + mvm_pkg::GAIN_W + 1;
    localparam int TW = PW - 16;
    localparam int QW = TW + 32;
    localparam int GW = mvm_pkg::GAIN_W;

    logic [31:0] mem [DEPTH];
    logic [31:0] mem_q_reg;

    logic [FW-1:0] frames_reg [SOUND_COUNT];
    logic          vbusy_reg  [VOICE_COUNT];
    logic [SW-1:0] vsound_reg [VOICE_COUNT];
    logic [FW-1:0] vpos_reg   [VOICE_COUNT];
    logic [GW-1:0] gain_reg;
    logic [GW-1:0] gain_next;
    logic          active_reg;

    logic snd_ok;
    assign snd_ok = (32'(sound_index) < 32'(SOUND_COUNT));

    // Load path.
    logic          load_en;
    logic [AW-1:0] load_addr;
    assign load_en = cmd.accept && (op == mvm_pkg::OP_LOAD) && snd_ok
                     && (32'(frame_address) < 32'(MAX_FRAMES));
    assign load_addr = AW'(32'(sound_index) * 32'(MAX_FRAMES) + 32'(frame_address));

    // Length clamp.
    logic [FW-1:0] len_sat;
    assign len_sat = (32'(sound_length) > 32'(MAX_FRAMES)) ? FW'(MAX_FRAMES)
                                                           : FW'(sound_length);

    // First free voice.
    logic          trig_found;
    logic [IW-1:0] trig_sel;
    always_comb
    begin
        trig_found = 1'b0;
        trig_sel   = '0;
        for (int i = 0; i < VOICE_COUNT; i++)
        begin
            if (!trig_found && !vbusy_reg[i])
            begin
                trig_found = 1'b1;
                trig_sel   = IW'(i);
            end
        end
    end

    // Gain slew toward the volume target.
    logic [3:0]    vol_sat;
    logic [GW-1:0] target;
    logic [GW:0]   gain_up;
    always_comb
    begin
        vol_sat = (volume_level > mvm_pkg::VOL_MAX) ? mvm_pkg::VOL_MAX : volume_level;
        target  = {vol_sat, 16'd0};
        gain_up = {1'b0, gain_reg} + {1'b0, mvm_pkg::GAIN_STEP};
        gain_next = gain_reg;
        if (gain_reg < target)
            gain_next = (gain_up > {1'b0, target}) ? target : gain_up[GW-1:0];
        else if (gain_reg > target)
            gain_next = ((gain_reg - target) < mvm_pkg::GAIN_STEP) ? target
                                                                  : gain_reg - mvm_pkg::GAIN_STEP;
    end

    // Voice lookup for the issued voice.
    logic          v_busy;
    logic [SW-1:0] v_snd;
    logic [FW-1:0] v_pos;
    logic [FW-1:0] v_len;
    logic [FW-1:0] v_tail;
    logic [FW-1:0] v_edge;
    logic [6:0]    v_gain;
    logic          v_hit;
    logic [AW-1:0] v_addr;
    always_comb
    begin
        v_busy = vbusy_reg[voice_idx];
        v_snd  = vsound_reg[voice_idx];
        v_pos  = vpos_reg[voice_idx];
        v_len  = frames_reg[v_snd];
        v_hit  = cmd.issue && v_busy && (v_pos < v_len);
        v_tail = v_len - v_pos - 1'b1;
        v_edge = (v_tail < v_pos) ? v_tail : v_pos;
        v_gain = (v_edge < FW'(mvm_pkg::FADE_LEN)) ? v_edge[6:0] : mvm_pkg::FADE_LEN;
        v_addr = AW'(32'(v_snd) * 32'(MAX_FRAMES) + 32'(v_pos));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SOUND_COUNT; s++)
                frames_reg[s] <= '0;
            for (int i = 0; i < VOICE_COUNT; i++)
            begin
                vbusy_reg[i]  <= 1'b0;
                vsound_reg[i] <= '0;
                vpos_reg[i]   <= '0;
            end
            gain_reg <= mvm_pkg::GAIN_RESET;
        end
        else
        begin
            if (cmd.accept && (op == mvm_pkg::OP_LENGTH) && snd_ok)
                frames_reg[sound_index[SW-1:0]] <= len_sat;
            if (cmd.accept && (op == mvm_pkg::OP_TRIGGER) && snd_ok && trig_found)
            begin
                vbusy_reg[trig_sel]  <= 1'b1;
                vsound_reg[trig_sel] <= sound_index[SW-1:0];
                vpos_reg[trig_sel]   <= '0;
            end
            if (cmd.accept && (op == mvm_pkg::OP_FRAME))
                gain_reg <= gain_next;
            if (cmd.issue && v_busy)
            begin
                if (v_hit)
                    vpos_reg[voice_idx] <= v_pos + 1'b1;
                else
                    vbusy_reg[voice_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_en)
            mem[load_addr] <= {right_in, left_in};
        if (v_hit)
            mem_q_reg <= mem[v_addr];
    end

    // Fade pipeline: multiply, divide by 96 through a reciprocal, accumulate.
    logic               s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic [6:0]         s1_gain_reg;
    logic signed [23:0] prod_reg [2];
    logic [32:0]        rp_reg   [2];
    logic               neg_reg  [2];
    logic signed [ACC_W-1:0] acc_reg [2];

    logic signed [15:0] smp [2];
    logic signed [7:0]  gs;
    logic [23:0]        pmag [2];
    logic signed [16:0] fval [2];
    always_comb
    begin
        smp[0] = mem_q_reg[15:0];
        smp[1] = mem_q_reg[31:16];
        gs     = {1'b0, s1_gain_reg};
        for (int c = 0; c < 2; c++)
        begin
            pmag[c] = prod_reg[c][23] ? 24'(-prod_reg[c]) : 24'(prod_reg[c]);
            fval[c] = neg_reg[c] ? -$signed({1'b0, rp_reg[c][32:17]})
                                 : $signed({1'b0, rp_reg[c][32:17]});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            active_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= v_hit;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            if (cmd.accept && (op == mvm_pkg::OP_FRAME))
                active_reg <= 1'b0;
            else if (v_hit)
                active_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (v_hit)
            s1_gain_reg <= v_gain;
        for (int c = 0; c < 2; c++)
        begin
            prod_reg[c] <= 24'(smp[c]) * 24'(gs);
            rp_reg[c]   <= 33'(pmag[c][21:5]) * mvm_pkg::RECIP3;
            neg_reg[c]  <= prod_reg[c][23];
            if (cmd.accept && (op == mvm_pkg::OP_FRAME))
                acc_reg[c] <= '0;
            else if (s3_valid_reg)
                acc_reg[c] <= acc_reg[c] + ACC_W'(fval[c]);
        end
    end

    // Master scaling: times gain, divide by 655360 toward zero, then saturate.
    logic signed [PW-1:0] smul_reg [2];
    logic [QW-1:0]        sq_reg   [2];
    logic                 sneg_reg [2];
    logic signed [15:0]   out_reg  [2];
    logic                 out_active_reg;

    logic [PW-1:0] smag [2];
    logic [TW-1:0] sq   [2];
    logic signed [15:0] sat [2];
    always_comb
    begin
        for (int c = 0; c < 2; c++)
        begin
            smag[c] = smul_reg[c][PW-1] ? PW'(-smul_reg[c]) : PW'(smul_reg[c]);
            sq[c]   = TW'(sq_reg[c] >> 35);
            if (!sneg_reg[c])
                sat[c] = (sq[c] > TW'(32767)) ? 16'sd32767 : 16'(sq[c]);
            else
                sat[c] = (sq[c] > TW'(32768)) ? -16'sd32768 : 16'(-sq[c]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 2; c++)
        begin
            if (cmd.mul)
                smul_reg[c] <= PW'(acc_reg[c]) * PW'($signed({1'b0, gain_reg}));
            if (cmd.div)
            begin
                sq_reg[c]   <= QW'(smag[c][PW-1:16]) * QW'(mvm_pkg::RECIP10);
                sneg_reg[c] <= smul_reg[c][PW-1];
            end
            if (cmd.sat)
                out_reg[c] <= sat[c];
        end
        if (cmd.sat)
            out_active_reg <= active_reg;
    end

    assign left_out   = out_reg[0];
    assign right_out  = out_reg[1];
    assign any_active = out_active_reg;

endmodule

`default_nettype wire

/* rtl/core/multi_voice_sample_mixer.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_voice_sample_mixer
// Stereo mixer of stored sounds on a set of voices with faded edges.
// ----------------------------------------------------------------------------
// A command is transferred when start is high and busy is low. Load, length
// and trigger commands complete in the cycle of the transfer and leave busy
// low. An output frame keeps busy high while the sequencer reads one voice
// per cycle from the single read port of the sound memory, then drains the
// fade pipeline and runs the multiply, divide and saturate steps of master
// scaling. The mixed frame is on the outputs with done high for one cycle,
// the first cycle in which busy is low again; the receiver cannot stall
// it, so it must take every frame when done is high.
module multi_voice_sample_mixer #(
    parameter int VOICE_COUNT = mvm_pkg::VOICE_COUNT_DEF,
    parameter int SOUND_COUNT = mvm_pkg::SOUND_COUNT_DEF,
    parameter int MAX_FRAMES  = mvm_pkg::MAX_FRAMES_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         op,
    input  wire logic [7:0]         sound_index,
    input  wire logic [13:0]        frame_address,
    input  wire logic signed [15:0] left_in,
    input  wire logic signed [15:0] right_in,
    input  wire logic [14:0]        sound_length,
    input  wire logic [3:0]         volume_level,
    output logic                    done,
    output logic signed [15:0]      left_out,
    output logic signed [15:0]      right_out,
    output logic                    any_active
);

    localparam int IW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

    mvm_pkg::cmd_t cmd;
    logic [IW-1:0] voice_idx;

    mvm_ctrl #(
        .VOICE_COUNT (VOICE_COUNT)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .op        (op),
        .busy      (busy),
        .done      (done),
        .voice_idx (voice_idx),
        .cmd       (cmd)
    );

    mvm_dpath #(
        .VOICE_COUNT (VOICE_COUNT),
        .SOUND_COUNT (SOUND_COUNT),
        .MAX_FRAMES  (MAX_FRAMES)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .voice_idx     (voice_idx),
        .op            (op),
        .sound_index   (sound_index),
        .frame_address (frame_address),
        .left_in       (left_in),
        .right_in      (right_in),
        .sound_length  (sound_length),
        .volume_level  (volume_level),
        .left_out      (left_out),
        .right_out     (right_out),
        .any_active    (any_active)
    );

    // A frame result only follows a busy period.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a preceding frame");

    // Commands other than an output frame never make the block busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (op != mvm_pkg::OP_FRAME)) |=> !busy)
        else $error("non-frame command raised busy");

    // With no voice playing the mix must be silent.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !any_active) |-> (left_out == 16'sd0 && right_out == 16'sd0))
        else $error("silent frame with nonzero output");

    // The strobe lasts a single cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held longer than one cycle");

endmodule

`default_nettype wire

/* tb/sv/tb_multi_voice_sample_mixer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_voice_sample_mixer
// Self-checking bench for the multi-voice sample mixer: a directed table of
// commands, then random sound loads, lengths, triggers and output frames;
// each frame is checked against the table or a behavioral mixer in the bench.
// ----------------------------------------------------------------------------
module tb_multi_voice_sample_mixer;

    localparam int NVOICE = 16;
    localparam int NSOUND = 7;
    localparam int NFRAME = 16384;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        mvm_pkg::op_t       op;
        logic [7:0]         snd;
        logic [13:0]        addr;
        logic signed [15:0] lin;
        logic signed [15:0] rin;
        logic [14:0]        len;
        logic [3:0]         vol;
    } command_t;

    typedef struct {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic               active;
    } mix_frame_t;

    typedef struct {
        command_t   cmd;
        logic       has_exp;
        mix_frame_t exp;
    } table_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [1:0] op = '0;
    logic [7:0] sound_index = '0;
    logic [13:0] frame_address = '0;
    logic signed [15:0] left_in = '0;
    logic signed [15:0] right_in = '0;
    logic [14:0] sound_length = '0;
    logic [3:0] volume_level = '0;
    logic done;
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
    logic any_active;

    // Bench copy of the mixer state.
    logic [31:0] pcm_mem [int];
    logic [14:0] snd_len [NSOUND];
    logic        v_busy [NVOICE];
    logic [2:0]  v_snd [NVOICE];
    logic [14:0] v_pos [NVOICE];
    longint      gain;

    mix_frame_t pending_frames[$];
    mix_frame_t typed_frames[$];
    logic       typed_valid[$];
    int errors = 0;
    int idle_cycles = 0;
    // Count of frames loaded in order from address 0 per sound; lengths never
    // exceed it, so no read touches an unwritten frame.
    int loaded_top [NSOUND];

    multi_voice_sample_mixer dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int scale_channel(int mixed);
        longint v;
        v = (longint'(mixed) * gain) / 655360;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return int'(v);
    endfunction

    function automatic void mix_command(command_t c);
        longint target;
        int sum_l, sum_r, p, n, edge_d, g;
        logic [31:0] w;
        mix_frame_t f;
        case (c.op)
            mvm_pkg::OP_LOAD: if (c.snd < NSOUND)
                pcm_mem[c.snd * NFRAME + c.addr] = {c.rin, c.lin};
            mvm_pkg::OP_LENGTH: if (c.snd < NSOUND)
                snd_len[c.snd] = (c.len > NFRAME) ? 15'(NFRAME) : c.len;
            mvm_pkg::OP_TRIGGER: if (c.snd < NSOUND)
            begin
                for (int i = 0; i < NVOICE; i++)
                begin
                    if (!v_busy[i])
                    begin
                        v_busy[i] = 1'b1;
                        v_snd[i] = c.snd[2:0];
                        v_pos[i] = '0;
                        break;
                    end
                end
            end
            default:
            begin
                target = longint'((c.vol > 10) ? 10 : c.vol) * 65536;
                if (gain < target) gain = (gain + 256 > target) ? target : gain + 256;
                else if (gain > target) gain = (gain - 256 < target) ? target : gain - 256;
                sum_l = 0;
                sum_r = 0;
                f.active = 1'b0;
                for (int i = 0; i < NVOICE; i++)
                begin
                    if (!v_busy[i]) continue;
                    p = v_pos[i];
                    n = snd_len[v_snd[i]];
                    if (p >= n)
                    begin
                        v_busy[i] = 1'b0;
                        continue;
                    end
                    f.active = 1'b1;
                    edge_d = (n - 1 - p < p) ? n - 1 - p : p;
                    g = (edge_d < 96) ? edge_d : 96;
                    w = pcm_mem.exists(v_snd[i] * NFRAME + p) ?
                        pcm_mem[v_snd[i] * NFRAME + p] : 32'd0;
                    sum_l += int'($signed(w[15:0])) * g / 96;
                    sum_r += int'($signed(w[31:16])) * g / 96;
                    v_pos[i] = 15'(p + 1);
                end
                f.left = 16'(scale_channel(sum_l));
                f.right = 16'(scale_channel(sum_r));
                pending_frames.push_back(f);
            end
        endcase
    endfunction

    // Results are sampled at the rising edge that ends the done cycle.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_frames.size() == 0)
            begin
                $error("unexpected frame left=%0d right=%0d", left_out, right_out);
                errors++;
            end
            else
            begin
                mix_frame_t e;
                e = pending_frames.pop_front();
                if (typed_valid.size() > 0)
                begin
                    if (typed_valid.pop_front()) e = typed_frames.pop_front();
                end
                if (left_out !== e.left)
                begin
                    $error("left_out expected %0d actual %0d", e.left, left_out);
                    errors++;
                end
                if (right_out !== e.right)
                begin
                    $error("right_out expected %0d actual %0d", e.right, right_out);
                    errors++;
                end
                if (any_active !== e.active)
                begin
                    $error("any_active expected %0d actual %0d", e.active, any_active);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[multi_voice_sample_mixer] ERROR");
            $finish;
        end
    end

    // Called right after a transfer; start drops only when a real gap follows.
    task automatic random_gap();
        int r, n;
        r = $urandom_range(0, 99);
        if (r < 45) n = 0;
        else if (r < 92) n = $urandom_range(1, 3);
        else n = $urandom_range(10, 60);
        if (n > 0) start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic send_command(command_t c, logic gaps);
        if (gaps) random_gap();
        op <= c.op;
        sound_index <= c.snd;
        frame_address <= c.addr;
        left_in <= c.lin;
        right_in <= c.rin;
        sound_length <= c.len;
        volume_level <= c.vol;
        start <= 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);
        mix_command(c);
    endtask

    function automatic command_t make_cmd(mvm_pkg::op_t o, int s, int a, int l, int r,
                                          int n, int v);
        command_t c;
        c.op = o;
        c.snd = 8'(s);
        c.addr = 14'(a);
        c.lin = 16'(l);
        c.rin = 16'(r);
        c.len = 15'(n);
        c.vol = 4'(v);
        return c;
    endfunction

    function automatic command_t random_cmd();
        int r, s, top;
        r = $urandom_range(0, 99);
        s = $urandom_range(0, 6);
        top = loaded_top[s];
        if (r < 2)
        begin
            // Ignored commands: bad sound number.
            return make_cmd(mvm_pkg::op_t'($urandom_range(0, 2)), $urandom_range(7, 255),
                            $urandom, $urandom, $urandom, $urandom, 0);
        end
        else if (r < 30)
        begin
            int a;
            a = (top < 200 && $urandom_range(0, 3) != 0) ? top : $urandom_range(0, 16383);
            if (a == top && top < NFRAME) loaded_top[s] = top + 1;
            return make_cmd(mvm_pkg::OP_LOAD, s, a, $urandom, $urandom, 0, 0);
        end
        else if (r < 36)
        begin
            return make_cmd(mvm_pkg::OP_LENGTH, s, 0, 0, 0, $urandom_range(0, top), 0);
        end
        else if (r < 46)
        begin
            return make_cmd(mvm_pkg::OP_TRIGGER, s, 0, 0, 0, 0, 0);
        end
        return make_cmd(mvm_pkg::OP_FRAME, 0, 0, 0, 0, 0,
                        ($urandom_range(0, 9) == 0) ? $urandom_range(11, 15)
                                                    : $urandom_range(0, 10));
    endfunction

    initial
    begin
        table_row_t rows[$];
        table_row_t row;
        mix_frame_t silent_full;
        silent_full = '{left: 16'sd0, right: 16'sd0, active: 1'b0};
        for (int s = 0; s < NSOUND; s++)
        begin
            snd_len[s] = '0;
            loaded_top[s] = 0;
        end
        for (int i = 0; i < NVOICE; i++)
        begin
            v_busy[i] = 1'b0;
            v_snd[i] = '0;
            v_pos[i] = '0;
        end
        gain = 655360;

        // Directed table.
        row.has_exp = 1'b1; row.exp = silent_full;
        row.cmd = make_cmd(mvm_pkg::OP_FRAME, 0, 0, 0, 0, 0, 10); rows.push_back(row);
        row.has_exp = 1'b0;
        row.cmd = make_cmd(mvm_pkg::OP_LOAD, 9, 0, 5, 5, 0, 0); rows.push_back(row);
        row.cmd = make_cmd(mvm_pkg::OP_LENGTH, 255, 0, 0, 0, 5, 0); rows.push_back(row);
        row.cmd = make_cmd(mvm_pkg::OP_TRIGGER, 7, 0, 0, 0, 0, 0); rows.push_back(row);
        for (int a = 0; a < 3; a++)
        begin
            row.cmd = make_cmd(mvm_pkg::OP_LOAD, 6, a, 32767, -32768, 0, 0);
            rows.push_back(row);
        end
        row.cmd = make_cmd(mvm_pkg::OP_LOAD, 0, 16383, -32768, 32767, 0, 0); rows.push_back(row);
        row.cmd = make_cmd(mvm_pkg::OP_LENGTH, 6, 0, 0, 0, 3, 0); rows.push_back(row);
        row.cmd = make_cmd(mvm_pkg::OP_TRIGGER, 6, 0, 0, 0, 0, 0); rows.push_back(row);
        row.cmd = make_cmd(mvm_pkg::OP_TRIGGER, 0, 0, 0, 0, 0, 0); rows.push_back(row);
        for (int k = 0; k < 4; k++)
        begin
            row.cmd = make_cmd(mvm_pkg::OP_FRAME, 0, 0, 0, 0, 0, 15); rows.push_back(row);
        end
        for (int k = 0; k < 17; k++)
        begin
            row.cmd = make_cmd(mvm_pkg::OP_TRIGGER, 6, 0, 0, 0, 0, 0); rows.push_back(row);
        end
        row.cmd = make_cmd(mvm_pkg::OP_FRAME, 0, 0, 0, 0, 0, 0); rows.push_back(row);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            if (rows[i].cmd.op == mvm_pkg::OP_FRAME)
            begin
                typed_valid.push_back(rows[i].has_exp);
                if (rows[i].has_exp) typed_frames.push_back(rows[i].exp);
            end
            send_command(rows[i].cmd, 1'b0);
        end
        // Sound 0: long length, then shorten to zero.
        send_command(make_cmd(mvm_pkg::OP_LENGTH, 0, 0, 0, 0, 32767, 0), 1'b0);
        send_command(make_cmd(mvm_pkg::OP_LENGTH, 0, 0, 0, 0, 0, 0), 1'b0);
        send_command(make_cmd(mvm_pkg::OP_FRAME, 0, 0, 0, 0, 0, 10), 1'b0);
        for (int s = 0; s < NSOUND; s++) loaded_top[s] = (s == 6) ? 3 : 0;
        // Sound 0 frame 16383 is written, but lower frames are not; keep it out.

        for (int k = 0; k < 1800; k++)
        begin
            send_command(random_cmd(), 1'b1);
            if (k == 900)
            begin
                // Hold off until all frames in flight have come back.
                start <= 1'b0;
                @(posedge clk);
                while (pending_frames.size() != 0) @(posedge clk);
            end
        end

        start <= 1'b0;
        @(posedge clk);
        while (pending_frames.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0) $display("[multi_voice_sample_mixer] OK");
        else $display("[multi_voice_sample_mixer] ERROR");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/mvm_pkg.sv
rtl/core/mvm_ctrl.sv
rtl/core/mvm_dpath.sv
rtl/core/multi_voice_sample_mixer.sv
tb/sv/tb_multi_voice_sample_mixer.sv
